/* hdl/b64d_pkg.sv */
`default_nettype none
package b64d_pkg;

   // ASCII code of the pad character '='
   localparam logic [7:0] PAD_CODE = 8'h3D;

   // default number of group entries between front and back
   localparam int QUEUE_DEPTH = 4;

   // Code values the lookup maps to
   localparam logic [6:0] VAL_PLUS = 7'd62;
   localparam logic [6:0] VAL_SLASH = 7'd63;
   localparam logic [6:0] VAL_NUL = 7'd64;
   localparam logic [6:0] VAL_UPPER_BASE = 7'd0;
   localparam logic [6:0] VAL_LOWER_BASE = 7'd26;
   localparam logic [6:0] VAL_DIGIT_BASE = 7'd52;

   // Index of the last valid byte in a group entry
   localparam logic [1:0] LAST_IS_B0 = 2'd0;
   localparam logic [1:0] LAST_IS_B1 = 2'd1;

   // One decoded group: bytes packed front to back, so that b1 holds the
   // third byte when the second one is suppressed by a pad.
   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] last_idx;
      logic       fin;
   } grp_type;

   // Character to 7-bit value; '=' and unknown codes give zero, NUL gives 64
   function automatic logic [6:0] sym_value(input logic [7:0] c);
      logic [6:0] v;
      v = 7'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v = VAL_UPPER_BASE + 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = VAL_LOWER_BASE + 7'(c - 8'h61);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = VAL_DIGIT_BASE + 7'(c - 8'h30);
      end else if (c == 8'h2B) begin
         v = VAL_PLUS;
      end else if (c == 8'h2F) begin
         v = VAL_SLASH;
      end else if (c == 8'h00) begin
         v = VAL_NUL;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

/* hdl/b64d_front.sv */
`default_nettype none
module b64d_front (
   input  wire              clock,
   input  wire              reset,
   input  wire              accept,
   input  wire [7:0]        symbol,
   input  wire              final_symbol,
   output logic             push,
   output b64d_pkg::grp_type grp
);

   logic [1:0] pos_ff, pos_in;
   logic [6:0] held_ff [3];
   logic [6:0] held_in [3];
   logic       third_pad_ff, third_pad_in;

   logic [6:0] val_c;
   logic       is_pad;
   logic [6:0] v0, v1, v2, v3;
   logic       pad2, pad3;
   logic [7:0] byte0, byte1, byte2;
   logic       completes;

   assign val_c     = b64d_pkg::sym_value(symbol);
   assign is_pad    = (symbol == b64d_pkg::PAD_CODE);
   assign completes = (pos_ff == 2'd3) || final_symbol;
   assign push      = accept && completes;

   // fill the group with implied pads where it is short
   always_comb begin
      v0   = (pos_ff == 2'd0) ? val_c : held_ff[0];
      v1   = (pos_ff == 2'd1) ? val_c : ((pos_ff >= 2'd2) ? held_ff[1] : 7'd0);
      v2   = (pos_ff == 2'd2) ? val_c : ((pos_ff == 2'd3) ? held_ff[2] : 7'd0);
      v3   = (pos_ff == 2'd3) ? val_c : 7'd0;
      pad2 = (pos_ff == 2'd3) ? third_pad_ff : ((pos_ff == 2'd2) ? is_pad : 1'b1);
      pad3 = (pos_ff == 2'd3) ? is_pad : 1'b1;
   end

   assign byte0 = {v0[5:0], 2'b00} | {5'b0, v1[6:4]};
   assign byte1 = {v1[3:0], 4'b0000} | {3'b0, v2[6:2]};
   assign byte2 = {v2[1:0], 6'b000000} | {1'b0, v3};

   always_comb begin
      grp.b0       = byte0;
      grp.b1       = pad2 ? byte2 : byte1;
      grp.b2       = byte2;
      grp.last_idx = 2'(!pad2) + 2'(!pad3);
      grp.fin      = final_symbol;
   end

   always_comb begin
      pos_in       = pos_ff;
      third_pad_in = third_pad_ff;
      held_in      = held_ff;
      if (accept) begin
         if (completes) begin
            pos_in       = 2'd0;
            third_pad_in = 1'b0;
         end else begin
            pos_in = pos_ff + 2'd1;
            unique case (pos_ff)
               2'd0: held_in[0] = val_c;
               2'd1: held_in[1] = val_c;
               default: begin
                  held_in[2]   = val_c;
                  third_pad_in = is_pad;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 2'd0;
         third_pad_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         third_pad_ff <= third_pad_in;
      end
      held_ff <= held_in;
   end

endmodule
`default_nettype wire

/* hdl/b64d_queue.sv */
`default_nettype none
module b64d_queue #(
   parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  b64d_pkg::grp_type push_grp,
   output logic              has_space,
   input  wire               pop,
   output logic              not_empty,
   output b64d_pkg::grp_type head_grp
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   b64d_pkg::grp_type mem [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign has_space = (cnt_ff != CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_grp  = mem[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem[wr_ff] <= push_grp;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> has_space)
      else $error("group queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("group queue read while empty");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> not_empty && (cnt_ff == $past(cnt_ff) + CW'(1)))
      else $error("group entry lost on push");

endmodule
`default_nettype wire

/* hdl/b64d_back.sv */
`default_nettype none
module b64d_back (
   input  wire               clock,
   input  wire               reset,
   input  wire               head_valid,
   input  b64d_pkg::grp_type head_grp,
   output logic              pop,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       load, at_end;
   logic [7:0] sel_byte;

   assign load   = head_valid && (!valid_ff || rsp_tready);
   assign at_end = (idx_ff == head_grp.last_idx);
   assign pop    = load && at_end;

   always_comb begin
      case (idx_ff)
         b64d_pkg::LAST_IS_B0: sel_byte = head_grp.b0;
         b64d_pkg::LAST_IS_B1: sel_byte = head_grp.b1;
         default:              sel_byte = head_grp.b2;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (!valid_ff || rsp_tready) begin
         valid_in = head_valid;
      end
      if (load) begin
         data_in = sel_byte;
         last_in = head_grp.fin && at_end;
         idx_in  = at_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> idx_ff <= head_grp.last_idx)
      else $error("byte index past end of group");

   a_idx_clear_on_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == 2'd0)
      else $error("byte index not cleared after group");

   a_last_only_on_end: assert property (@(posedge clock) disable iff (reset)
      load && !at_end |=> !rsp_tlast)
      else $error("end of stream flagged inside a group");

endmodule
`default_nettype wire

/* hdl/base64_lenient_decoder_top.sv */
`default_nettype none
// Lenient base64 decoder, one text character per transaction.
//
// req channel: one character per transaction; req_tlast marks the final
//   character of a text. The block completes a short final group with
//   implied pads. Unknown characters and '=' decode as zero, NUL as 64.
// rsp channel: one decoded byte per transaction; rsp_tlast marks the last
//   byte of the whole text.
// Throughput: one character per cycle sustained while rsp_tready is high.
//   The back end sends one byte per cycle, and a group of four characters
//   yields at most three bytes. A completed group is pushed into the group
//   queue; its first byte then passes through the output register to rsp,
//   and the group's further bytes follow one per cycle while rsp_tready
//   is high.
// Stalls: when rsp_tready is low the output register holds; the group queue
//   (QUEUE_DEPTH entries) keeps absorbing finished groups, and req_tready
//   drops only while that queue is full.
// Reset: synchronous, active high; clears the group position, the queue and
//   the output valid. Ready is up in the first cycle after reset.
module base64_lenient_decoder_top #(
   parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [7:0]  req_tdata,   // [7:0] symbol
   input  wire        req_tlast,   // final_symbol
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic       rsp_tlast    // end_of_stream
);

   logic              accept;
   logic              push;
   logic              pop;
   logic              has_space;
   logic              not_empty;
   b64d_pkg::grp_type push_grp;
   b64d_pkg::grp_type head_grp;

   // front end takes characters whenever the queue can hold one more group
   assign req_tready = has_space;
   assign accept     = req_tvalid && req_tready;

   b64d_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .symbol       (req_tdata),
      .final_symbol (req_tlast),
      .push         (push),
      .grp          (push_grp)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_grp  (push_grp),
      .has_space (has_space),
      .pop       (pop),
      .not_empty (not_empty),
      .head_grp  (head_grp)
   );

   // back end walks the head group one byte a transaction
   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (not_empty),
      .head_grp   (head_grp),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

/* tb/tb_base64_lenient_decoder_top.sv */
`default_nettype none
// Testbench for the lenient base64 decoder.
//
// Stimulus runs as a series of named tests from one initial block. Every
// character goes through send_symbol, which idles at random, waits for the
// req handshake and runs the decode predictor on each accepted transaction.
// The predictor queues the bytes it expects into expected_bytes. A separate
// process pops that queue on every rsp transaction and compares it field by
// field. rsp_tready is driven from its own process. That process adds random
// stalls and can also hold off for a long stretch on request.
module tb_base64_lenient_decoder_top;

   // One decoded byte as it should appear on rsp
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } decoded_byte_type;

   localparam int    CYCLE_LIMIT  = 250000;
   localparam int    LONG_HOLD    = 300;
   localparam int    DRAIN_CYCLES = 20;
   localparam int    RANDOM_ITEMS = 220;
   localparam string B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = 8'h00;  // [7:0] symbol
   logic       req_tlast   = 1'b0;   // final_symbol
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] data_byte
   logic       rsp_tlast;            // end_of_stream

   // Predictor state: the group being gathered
   logic [1:0] group_pos;
   logic [6:0] held_sextets [3];
   logic       third_pad;

   decoded_byte_type expected_bytes[$];
   int               err_count   = 0;
   int               cycle_count = 0;
   int               items_sent  = 0;
   bit               no_idle     = 1'b0;

   // Long hold-off handshake between the test and the rsp_tready process
   logic hold_req    = 1'b0;
   logic hold_ack    = 1'b0;
   int   stall_left  = 0;

   base64_lenient_decoder_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle) return 0;
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Character to 7-bit value: '=' and unknown codes give 0, NUL gives 64
   function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return b64d_pkg::VAL_UPPER_BASE + 7'(c - "A");
      if (c >= "a" && c <= "z") return b64d_pkg::VAL_LOWER_BASE + 7'(c - "a");
      if (c >= "0" && c <= "9") return b64d_pkg::VAL_DIGIT_BASE + 7'(c - "0");
      if (c == "+") return b64d_pkg::VAL_PLUS;
      if (c == "/") return b64d_pkg::VAL_SLASH;
      if (c == 8'h00) return b64d_pkg::VAL_NUL;
      return 7'd0;
   endfunction

   task automatic clear_group();
      group_pos       = 2'd0;
      held_sextets[0] = 7'd0;
      held_sextets[1] = 7'd0;
      held_sextets[2] = 7'd0;
      third_pad       = 1'b0;
   endtask

   // Decode predictor: advance the group by one character, queue any bytes
   task automatic predict_decode(input logic [7:0] c, input logic is_last);
      logic [31:0]      v0, v1, v2, v3;
      logic             pad2, pad3;
      logic [7:0]       out_bytes [3];
      int               n;
      decoded_byte_type item;
      n = 0;
      if (group_pos != 2'd3) begin
         held_sextets[group_pos] = char_to_sextet(c);
         if (group_pos == 2'd2) third_pad = (c == b64d_pkg::PAD_CODE);
         if (!is_last) begin
            group_pos = group_pos + 2'd1;
            return;
         end
      end
      // group complete; missing characters count as implied pads
      v0   = 32'(held_sextets[0]);
      v1   = group_pos >= 2'd1 ? 32'(held_sextets[1]) : 32'd0;
      v2   = group_pos >= 2'd2 ? 32'(held_sextets[2]) : 32'd0;
      pad2 = group_pos >= 2'd2 ? third_pad : 1'b1;
      if (group_pos == 2'd3) begin
         v3   = 32'(char_to_sextet(c));
         pad3 = (c == b64d_pkg::PAD_CODE);
      end else begin
         v3   = 32'd0;
         pad3 = 1'b1;
      end
      out_bytes[n] = 8'((v0 << 2) | (v1 >> 4));
      n++;
      if (!pad2) begin
         out_bytes[n] = 8'((v1 << 4) | (v2 >> 2));
         n++;
      end
      if (!pad3) begin
         out_bytes[n] = 8'((v2 << 6) | v3);
         n++;
      end
      for (int k = 0; k < n; k++) begin
         item.data_byte     = out_bytes[k];
         item.end_of_stream = is_last && (k == n - 1);
         expected_bytes.insert(expected_bytes.size(), item);
      end
      clear_group();
   endtask

   // One req transaction. tvalid stays high across back-to-back sends.
   task automatic send_symbol(input logic [7:0] c, input logic is_last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_decode(c, is_last);
      items_sent++;
   endtask

   task automatic send_string(input string s, input bit ends_text);
      for (int i = 0; i < s.len(); i++) send_symbol(s[i], ends_text && i == s.len() - 1);
   endtask

   // Directed: plain groups, every pad placement, short final groups
   task automatic test_pad_placement();
      send_string("TWFu", 1'b1);   // "Man"
      send_string("TQ==", 1'b1);   // one byte
      send_string("TWE=", 1'b1);   // two bytes
      send_string("TWE", 1'b1);    // short final group of three
      send_string("TW", 1'b1);     // short final group of two
      send_string("T", 1'b1);      // lone final character
   endtask

   // Directed: early pad, unknown codes, NUL and alphabet edges
   task automatic test_odd_symbols();
      send_symbol(8'h00, 1'b0);    // NUL first: its extra bit drops out of byte 0
      send_symbol(8'hFF, 1'b0);    // unknown, all ones
      send_symbol("=", 1'b0);      // pad as third suppresses byte 1 only
      send_symbol("z", 1'b0);      // group completes without tlast
      send_string("=A*/", 1'b0);   // early pad never stops later bytes
      send_symbol(8'h00, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'h00, 1'b1);
      send_string("+9a0", 1'b1);
   endtask

   // Well-formed text: full groups with a random tail style
   task automatic send_wellformed_text();
      logic [7:0] text[$];
      int         groups;
      int         tail;
      groups = $urandom_range(1, 5);
      for (int g = 0; g < groups * 4; g++)
         text.insert(text.size(), B64_ALPHABET[$urandom_range(0, 63)]);
      tail = $urandom_range(0, 4);
      case (tail)
         1: text[$] = "=";
         2: begin
            text[$]              = "=";
            text[text.size() - 2] = "=";
         end
         3: void'(text.pop_back());
         4: begin
            void'(text.pop_back());
            void'(text.pop_back());
         end
         default: ;
      endcase
      foreach (text[i]) send_symbol(text[i], i == text.size() - 1);
   endtask

   // Noise: any byte code, NUL and pad made frequent
   task automatic send_noise_text();
      int         n;
      int         r;
      logic [7:0] c;
      n = $urandom_range(1, 14);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 9);
         if (r == 0) c = 8'h00;
         else if (r == 1) c = b64d_pkg::PAD_CODE;
         else c = 8'($urandom_range(0, 255));
         send_symbol(c, i == n - 1);
      end
   endtask

   // Receiver stalls for a long stretch while characters keep coming
   task automatic test_backpressure();
      no_idle  = 1'b1;
      hold_req <= ~hold_req;
      for (int i = 0; i < 48; i++) send_symbol(B64_ALPHABET[$urandom_range(0, 63)], i == 47);
      no_idle = 1'b0;
   endtask

   task automatic test_random_texts();
      int start;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 80) send_wellformed_text();
         else send_noise_text();
         // now and then a burst with no idling on either side
         no_idle = ($urandom_range(0, 9) == 0);
      end
      no_idle = 1'b0;
   endtask

   // rsp_tready: random stalls, plus the long hold-off on request
   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack   <= hold_req;
         stall_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker: every rsp transaction against the oldest expectation
   always @(posedge clock) begin
      decoded_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            err_count++;
            $error("unexpected transaction: data_byte %h end_of_stream %b",
                   rsp_tdata, rsp_tlast);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.data_byte) begin
               err_count++;
               $error("data_byte: expected %h, got %h", want.data_byte, rsp_tdata);
            end
            if (rsp_tlast !== want.end_of_stream) begin
               err_count++;
               $error("end_of_stream: expected %b, got %b", want.end_of_stream, rsp_tlast);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      clear_group();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_pad_placement();
      test_odd_symbols();
      test_backpressure();
      test_random_texts();

      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      // catch any stray bytes after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire
